[sv/idss_pkg.sv]
// ----------------------------------------------------------------------------
// idss_pkg: shared types and constants of the identification string scanner
// Result word layout, marker patterns and the character codes the scanner
// compares against.
// ----------------------------------------------------------------------------
package idss_pkg;

    // result kinds
    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    // most results one input word can cause
    localparam int unsigned MAX_RES = 5;

    // markers, first byte in the top position
    localparam logic [31:0] MARK_SCCS = 32'h4028_2329;  // "@(#)"
    localparam logic [31:0] MARK_ID   = 32'h2449_643A;  // "$Id:"

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    // one result word
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       found;
    } t_res;

    // results of one input word, oldest in entry 0
    typedef struct packed {
        t_res [MAX_RES-1:0] ent;
        logic [2:0]         cnt;
    } t_batch;

    // registered input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_end;
    } t_in_word;

endpackage

[sv/idss_if.sv]
// ----------------------------------------------------------------------------
// idss_in_if / idss_out_if: valid/ready channels of the scanner
// Input channel carries a file byte or an end-of-file flag; output channel
// carries one result word.
// ----------------------------------------------------------------------------
interface idss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_end;

    modport source (output valid, output data_byte, output is_end, input ready);
    modport sink   (input valid, input data_byte, input is_end, output ready);
endinterface

interface idss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       found_any;
    logic       last;

    modport source (output valid, output out_byte, output out_kind,
                     output found_any, output last, input ready);
    modport sink   (input valid, input out_byte, input out_kind,
                    input found_any, input last, output ready);
endinterface

[sv/idss_in_stage.sv]
// ----------------------------------------------------------------------------
// idss_in_stage: input register
// Captures one input word; frees up in the same cycle the core consumes it.
// ----------------------------------------------------------------------------
module idss_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    idss_in_if.sink           i_in,
    input  logic              i_consume,
    output logic              o_valid,
    output idss_pkg::t_in_word o_word
);
    import idss_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign i_in.ready = !r_valid || i_consume;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_consume) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_word.data_byte <= i_in.data_byte;
            r_word.is_end    <= i_in.is_end;
        end
    end

endmodule

[sv/idss_scan_core.sv]
// ----------------------------------------------------------------------------
// idss_scan_core: marker search, skip and text logic
// Holds the per-file scan state and works out, in one pass, the next state
// and the list of result words caused by the registered input word.
// ----------------------------------------------------------------------------
module idss_scan_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_valid,
    input  idss_pkg::t_in_word i_word,
    input  logic               i_can_load,
    output logic               o_consume,
    output logic               o_load,
    output idss_pkg::t_batch   o_batch
);
    import idss_pkg::*;

    // scan phases
    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_TEXT   = 2'd2;

    logic        r_first_only;
    logic [23:0] r_hist,      n_hist;
    logic [1:0]  r_phase,     n_phase;
    logic [23:0] r_held,      n_held;
    logic [1:0]  r_held_cnt,  n_held_cnt;
    logic        r_nonempty,  n_nonempty;
    logic        r_file_done, n_file_done;
    logic        r_matched,   n_matched;

    logic [7:0]  b;
    logic        is_term;
    logic        is_blank;
    logic        hit_marker;
    logic        skip_match;
    logic [31:0] cand;
    logic        text_drop;
    logic        text_ne;
    t_batch      batch;

    assign o_consume = i_valid && i_can_load;
    assign o_load    = o_consume && (batch.cnt != 3'd0);
    assign o_batch   = batch;

    assign b        = i_word.data_byte;
    assign is_term  = (b == CH_NUL) || (b == CH_GT) || (b == CH_QUOTE) ||
                      (b == CH_BSL) || (b == CH_LF);
    assign is_blank = (b == CH_SPACE) || (b == CH_TAB);

    // marker completes on this byte
    assign hit_marker = ((r_hist == MARK_SCCS[31:8]) && (b == MARK_SCCS[7:0])) ||
                        ((r_hist == MARK_ID[31:8])   && (b == MARK_ID[7:0]));

    // held bytes plus this byte still a marker prefix
    assign cand = {r_held, b};
    always_comb begin
        unique case (r_held_cnt)
            2'd0: skip_match = (cand[7:0] == MARK_SCCS[31:24]) ||
                               (cand[7:0] == MARK_ID[31:24]);
            2'd1: skip_match = (cand[15:0] == MARK_SCCS[31:16]) ||
                               (cand[15:0] == MARK_ID[31:16]);
            2'd2: skip_match = (cand[23:0] == MARK_SCCS[31:8]) ||
                               (cand[23:0] == MARK_ID[31:8]);
            2'd3: skip_match = (cand == MARK_SCCS) || (cand == MARK_ID);
            default: skip_match = 1'b0;
        endcase
    end

    // trailing " $" is dropped when text came before it
    assign text_drop = (r_held_cnt == 2'd2) && (r_held[15:0] == {CH_SPACE, MARK_ID[31:24]}) &&
                       r_nonempty;
    assign text_ne   = r_nonempty || (r_held_cnt != 2'd0);

    // next state and result list
    always_comb begin
        logic [2:0] k;
        logic [1:0] sel;
        k           = 3'd0;
        sel         = 2'd0;
        batch       = '0;
        n_hist      = r_hist;
        n_phase     = r_phase;
        n_held      = r_held;
        n_held_cnt  = r_held_cnt;
        n_nonempty  = r_nonempty;
        n_file_done = r_file_done;
        n_matched   = r_matched;

        if (o_consume) begin
            if (i_word.is_end) begin
                // flush pending string
                if (!r_file_done && (r_phase == PH_SKIP)) begin
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) < r_held_cnt) begin
                            sel = r_held_cnt - 2'(i) - 2'd1;
                            batch.ent[k] = '{data: r_held[{sel, 3'b000} +: 8],
                                             kind: KIND_TEXT, found: 1'b0};
                            k = k + 3'd1;
                        end
                    end
                    if (r_held_cnt != 2'd0) begin
                        batch.ent[k] = '{data: 8'd0, kind: KIND_END, found: 1'b0};
                        k = k + 3'd1;
                        n_matched = 1'b1;
                    end
                end else if (!r_file_done && (r_phase == PH_TEXT)) begin
                    if (!text_drop) begin
                        for (int i = 0; i < 2; i++) begin
                            if (2'(i) < r_held_cnt) begin
                                sel = r_held_cnt - 2'(i) - 2'd1;
                                batch.ent[k] = '{data: r_held[{sel, 3'b000} +: 8],
                                                 kind: KIND_TEXT, found: 1'b0};
                                k = k + 3'd1;
                            end
                        end
                    end
                    if (text_ne) begin
                        batch.ent[k] = '{data: 8'd0, kind: KIND_END, found: 1'b0};
                        k = k + 3'd1;
                        n_matched = 1'b1;
                    end
                end
                // end-of-file report, per-file state cleared
                batch.ent[k] = '{data: 8'd0, kind: KIND_REPORT, found: n_matched};
                k = k + 3'd1;
                n_hist      = '0;
                n_phase     = PH_SEARCH;
                n_held      = '0;
                n_held_cnt  = 2'd0;
                n_nonempty  = 1'b0;
                n_file_done = 1'b0;
            end else if (!r_file_done) begin
                unique case (r_phase)
                    PH_SKIP: begin
                        if ((r_held_cnt == 2'd0) && is_blank) begin
                            // leading blank skipped
                        end else if (skip_match) begin
                            if (r_held_cnt == 2'd3) begin
                                // repeated marker complete
                                n_held     = '0;
                                n_held_cnt = 2'd0;
                            end else begin
                                n_held     = cand[23:0];
                                n_held_cnt = r_held_cnt + 2'd1;
                            end
                        end else if (is_term) begin
                            // held bytes form the whole string
                            for (int i = 0; i < 3; i++) begin
                                if (2'(i) < r_held_cnt) begin
                                    sel = r_held_cnt - 2'(i) - 2'd1;
                                    batch.ent[k] = '{data: r_held[{sel, 3'b000} +: 8],
                                                     kind: KIND_TEXT, found: 1'b0};
                                    k = k + 3'd1;
                                end
                            end
                            if (r_held_cnt != 2'd0) begin
                                batch.ent[k] = '{data: 8'd0, kind: KIND_END, found: 1'b0};
                                k = k + 3'd1;
                                n_matched = 1'b1;
                                if (r_first_only) begin
                                    n_file_done = 1'b1;
                                end
                            end
                            n_phase    = PH_SEARCH;
                            n_hist     = '0;
                            n_held     = '0;
                            n_held_cnt = 2'd0;
                            n_nonempty = 1'b0;
                        end else begin
                            // failed marker: held bytes and this byte become text
                            for (int i = 0; i < 2; i++) begin
                                if (2'(i + 1) < r_held_cnt) begin
                                    sel = r_held_cnt - 2'(i) - 2'd1;
                                    batch.ent[k] = '{data: r_held[{sel, 3'b000} +: 8],
                                                     kind: KIND_TEXT, found: 1'b0};
                                    k = k + 3'd1;
                                end
                            end
                            n_held     = {8'd0, r_held[7:0], b};
                            n_held_cnt = (r_held_cnt != 2'd0) ? 2'd2 : 2'd1;
                            n_nonempty = (r_held_cnt >= 2'd2);
                            n_phase    = PH_TEXT;
                        end
                    end
                    PH_TEXT: begin
                        if (is_term) begin
                            if (!text_drop) begin
                                for (int i = 0; i < 2; i++) begin
                                    if (2'(i) < r_held_cnt) begin
                                        sel = r_held_cnt - 2'(i) - 2'd1;
                                        batch.ent[k] = '{data: r_held[{sel, 3'b000} +: 8],
                                                         kind: KIND_TEXT, found: 1'b0};
                                        k = k + 3'd1;
                                    end
                                end
                            end
                            if (text_ne) begin
                                batch.ent[k] = '{data: 8'd0, kind: KIND_END, found: 1'b0};
                                k = k + 3'd1;
                                n_matched = 1'b1;
                                if (r_first_only) begin
                                    n_file_done = 1'b1;
                                end
                            end
                            n_phase    = PH_SEARCH;
                            n_hist     = '0;
                            n_held     = '0;
                            n_held_cnt = 2'd0;
                            n_nonempty = 1'b0;
                        end else begin
                            // two-byte delay line for the " $" trim
                            if (r_held_cnt == 2'd2) begin
                                batch.ent[k] = '{data: r_held[15:8], kind: KIND_TEXT,
                                                 found: 1'b0};
                                k = k + 3'd1;
                                n_nonempty = 1'b1;
                            end else begin
                                n_held_cnt = r_held_cnt + 2'd1;
                            end
                            n_held = {8'd0, r_held[7:0], b};
                        end
                    end
                    default: begin
                        // searching
                        if (hit_marker) begin
                            n_phase    = PH_SKIP;
                            n_held     = '0;
                            n_held_cnt = 2'd0;
                            n_hist     = '0;
                        end else begin
                            n_hist = {r_hist[15:0], b};
                        end
                    end
                endcase
            end
        end
        batch.cnt = k;
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_only <= 1'b0;
        end else if (i_cfg_we) begin
            r_first_only <= i_cfg_wdata;
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_phase     <= PH_SEARCH;
            r_held      <= '0;
            r_held_cnt  <= 2'd0;
            r_nonempty  <= 1'b0;
            r_file_done <= 1'b0;
            r_matched   <= 1'b0;
        end else begin
            r_hist      <= n_hist;
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_held_cnt  <= n_held_cnt;
            r_nonempty  <= n_nonempty;
            r_file_done <= n_file_done;
            r_matched   <= n_matched;
        end
    end

endmodule

[sv/idss_res_buf.sv]
// ----------------------------------------------------------------------------
// idss_res_buf: result buffer
// Holds the result list of one input word and hands it out one word per
// handshake; reloads in the cycle its final word is taken.
// ----------------------------------------------------------------------------
module idss_res_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  idss_pkg::t_batch i_batch,
    output logic             o_can_load,
    idss_out_if.source       o_out
);
    import idss_pkg::*;

    t_res [MAX_RES-1:0] r_ent;
    logic [2:0]         r_cnt;
    logic [2:0]         r_idx;
    t_res               cur;
    logic               is_last;
    logic               take;

    assign cur     = r_ent[r_idx];
    assign is_last = (r_idx == (r_cnt - 3'd1));
    assign take    = o_out.valid && o_out.ready;

    assign o_can_load      = (r_cnt == 3'd0) || (take && is_last);
    assign o_out.valid     = (r_cnt != 3'd0);
    assign o_out.out_byte  = cur.data;
    assign o_out.out_kind  = cur.kind;
    assign o_out.found_any = cur.found;
    assign o_out.last      = is_last;

    // fill count and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
            r_idx <= 3'd0;
        end else if (take) begin
            if (is_last) begin
                r_cnt <= 3'd0;
                r_idx <= 3'd0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // result words
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_batch.ent;
        end
    end

endmodule

[sv/id_string_scanner_top.sv]
// ----------------------------------------------------------------------------
// id_string_scanner_top: identification string scanner
// Path: an input word is registered in the input stage; its result words are then
//   registered in the result buffer, and a busy result buffer can hold that load off.
// Throughput: one input word per cycle while each causes at most one result and
//   the output takes it; a word with more results holds the buffer until each is taken.
// Reset: synchronous, clears scan state, buffers and first_only; no clear pass.
// ----------------------------------------------------------------------------
module id_string_scanner_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    idss_in_if.sink    i_in,
    idss_out_if.source o_out
);
    import idss_pkg::*;

    logic     in_valid;
    t_in_word in_word;
    logic     consume;
    logic     can_load;
    logic     load;
    t_batch   batch;

    // input register
    idss_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_consume (consume),
        .o_valid   (in_valid),
        .o_word    (in_word)
    );

    // scan logic
    idss_scan_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (in_valid),
        .i_word      (in_word),
        .i_can_load  (can_load),
        .o_consume   (consume),
        .o_load      (load),
        .o_batch     (batch)
    );

    // result buffer
    idss_res_buf u_res_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_batch    (batch),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

[tb/id_string_scanner_top_tb.sv]
// ----------------------------------------------------------------------------
// id_string_scanner_top_tb: self-checking bench of the identification scanner
// Streams files of bytes and end-of-file words through the input channel,
// predicts every result word with a local copy of the scan state, and checks
// the output channel word by word. Both sides idle in random bursts but for the
// last part, and first_only is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module id_string_scanner_top_tb;
    import idss_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_WORDS    = 6;
    localparam logic [7:0]  CH_DOLLAR    = MARK_ID[31:24];
    localparam logic [7:0]  CH_LOWER_X   = 8'h78;

    typedef enum logic [1:0] {SCAN_SEARCH, SCAN_SKIP, SCAN_TEXT} t_scan_phase;

    typedef struct {
        logic [7:0] data_byte;
        logic       is_end;
    } t_in_item;

    typedef struct {
        logic [7:0] data;
        logic [1:0] kind;
        logic       found;
        logic       last;
    } t_res_word;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_cfg_we    = 1'b0;
    logic i_cfg_wdata = 1'b0;

    idss_in_if  in_if();
    idss_out_if out_if();

    id_string_scanner_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // clock, period 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted scan state
    logic        first_only_m;
    logic [23:0] hist;
    t_scan_phase phase;
    logic [31:0] held;
    int unsigned held_cnt;
    logic        str_nonempty;
    logic        file_done;
    logic        matched_any;

    t_res_word   step_words[$];
    t_res_word   exp_words[$];
    t_in_item    pending[$];
    t_in_item    drv_item;

    int unsigned queued;
    int unsigned err_cnt;
    int unsigned cycle_cnt;
    int unsigned src_gap;
    int unsigned snk_gap;
    logic        calm;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void clear_file_state();
        hist         = '0;
        phase        = SCAN_SEARCH;
        held         = '0;
        held_cnt     = 0;
        str_nonempty = 1'b0;
        file_done    = 1'b0;
    endfunction

    function automatic void put_word(logic [7:0] data, logic [1:0] kind, logic found);
        t_res_word w;
        if (step_words.size() < MAX_WORDS) begin
            w.data  = data;
            w.kind  = kind;
            w.found = found;
            w.last  = 1'b0;
            step_words.push_back(w);
        end
    endfunction

    function automatic logic is_stop(logic [7:0] b);
        return b == CH_NUL || b == CH_GT || b == CH_QUOTE || b == CH_BSL || b == CH_LF;
    endfunction

    // flush held text, drop a trailing " $" after real text, close the string
    function automatic void close_string();
        int unsigned i;
        if (!(held_cnt == 2 && held == {16'h0, CH_SPACE, CH_DOLLAR} && str_nonempty)) begin
            for (i = 0; i < held_cnt; i++)
                put_word(8'(held >> (8 * (held_cnt - 1 - i))), KIND_TEXT, 1'b0);
            if (held_cnt > 0)
                str_nonempty = 1'b1;
        end
        if (str_nonempty) begin
            put_word(8'h00, KIND_END, 1'b0);
            matched_any = 1'b1;
            if (first_only_m)
                file_done = 1'b1;
        end
        held         = '0;
        held_cnt     = 0;
        str_nonempty = 1'b0;
        phase        = SCAN_SEARCH;
        hist         = '0;
    endfunction

    // text bytes are delayed by two so a trailing " $" can be dropped
    function automatic void text_step(logic [7:0] b);
        if (is_stop(b)) begin
            close_string();
        end else begin
            if (held_cnt >= 2) begin
                put_word(held[15:8], KIND_TEXT, 1'b0);
                str_nonempty = 1'b1;
                held_cnt     = 2;
            end else begin
                held_cnt++;
            end
            held = {16'h0, held[7:0], b};
        end
    endfunction

    function automatic void search_step(logic [7:0] b);
        if ((hist == MARK_SCCS[31:8] && b == MARK_SCCS[7:0]) ||
            (hist == MARK_ID[31:8] && b == MARK_ID[7:0])) begin
            phase    = SCAN_SKIP;
            held     = '0;
            held_cnt = 0;
            hist     = '0;
        end else begin
            hist = {hist[15:0], b};
        end
    endfunction

    // bytes held as a possible repeated marker turn into text
    function automatic void replay_held(logic has_extra, logic [7:0] extra);
        logic [7:0]  seq [4];
        int unsigned n;
        int unsigned i;
        int unsigned cnt;
        n   = 0;
        cnt = (held_cnt > 3) ? 3 : held_cnt;
        for (i = 0; i < cnt; i++) begin
            seq[n] = 8'(held >> (8 * (cnt - 1 - i)));
            n++;
        end
        if (has_extra) begin
            seq[n] = extra;
            n++;
        end
        held         = '0;
        held_cnt     = 0;
        str_nonempty = 1'b0;
        phase        = SCAN_TEXT;
        for (i = 0; i < n; i++) begin
            if (phase == SCAN_TEXT)
                text_step(seq[i]);
            else
                search_step(seq[i]);
        end
    endfunction

    function automatic void skip_step(logic [7:0] b);
        int unsigned n;
        int unsigned sh;
        logic [31:0] cand;
        if (!(held_cnt == 0 && (b == CH_SPACE || b == CH_TAB))) begin
            n    = held_cnt + 1;
            cand = {held[23:0], b};
            sh   = 8 * (4 - n);
            if (n <= 4 && (cand == (MARK_SCCS >> sh) || cand == (MARK_ID >> sh))) begin
                if (n == 4) begin
                    held     = '0;
                    held_cnt = 0;
                end else begin
                    held     = cand;
                    held_cnt = n;
                end
            end else begin
                replay_held(1'b1, b);
            end
        end
    endfunction

    // one accepted input word: append its result words to the expected store
    function automatic void scan_step(logic [7:0] b, logic is_end);
        step_words.delete();
        if (is_end) begin
            if (!file_done) begin
                if (phase == SCAN_SKIP)
                    replay_held(1'b0, 8'h00);
                if (phase == SCAN_TEXT)
                    close_string();
            end
            put_word(8'h00, KIND_REPORT, matched_any);
            clear_file_state();
        end else if (!file_done) begin
            case (phase)
                SCAN_SKIP: skip_step(b);
                SCAN_TEXT: text_step(b);
                default:   search_step(b);
            endcase
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last = 1'b1;
        foreach (step_words[i])
            exp_words.push_back(step_words[i]);
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what);
        $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
        err_cnt++;
    endtask

    task automatic check_word();
        t_res_word w;
        if (exp_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word data=%02h kind=%0d",
                                      out_if.out_byte, out_if.out_kind));
        end else begin
            w = exp_words.pop_front();
            if (out_if.out_byte !== w.data)
                report_mismatch($sformatf("out_byte %02h, want %02h", out_if.out_byte, w.data));
            if (out_if.out_kind !== w.kind)
                report_mismatch($sformatf("out_kind %0d, want %0d", out_if.out_kind, w.kind));
            if (out_if.found_any !== w.found)
                report_mismatch($sformatf("found_any %0b, want %0b", out_if.found_any, w.found));
            if (out_if.last !== w.last)
                report_mismatch($sformatf("last %0b, want %0b", out_if.last, w.last));
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: predicts on acceptance, then offers the next pending word
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.data_byte <= 8'h00;
            in_if.is_end    <= 1'b0;
            src_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready)
                scan_step(in_if.data_byte, in_if.is_end);
            if (!in_if.valid || in_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_if.valid <= 1'b0;
                end else if (!calm && pending.size() > 0 && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(1, 15) - 1;
                    in_if.valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    drv_item = pending.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.data_byte <= drv_item.data_byte;
                    in_if.is_end    <= drv_item.is_end;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks accepted result words, stalls in bursts
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (out_if.valid && out_if.ready)
                check_word();
            if (snk_gap > 0) begin
                snk_gap--;
                out_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                snk_gap = $urandom_range(1, 15) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_byte(logic [7:0] b);
        t_in_item it;
        it.data_byte = b;
        it.is_end    = 1'b0;
        pending.push_back(it);
        queued++;
    endtask

    task automatic push_end();
        t_in_item it;
        it.data_byte = 8'($urandom_range(0, 255));
        it.is_end    = 1'b1;
        pending.push_back(it);
        queued++;
    endtask

    // leading nbytes of a marker
    task automatic push_marker(logic [31:0] mk, int unsigned nbytes);
        int unsigned k;
        for (k = 0; k < nbytes; k++)
            push_byte(8'(mk >> (8 * (3 - k))));
    endtask

    function automatic logic [7:0] pick_text_byte();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic logic [31:0] pick_marker();
        return $urandom_range(0, 1) ? MARK_SCCS : MARK_ID;
    endfunction

    // one file: noise, markers, blanks, repeats, text, optional " $", optional terminator
    task automatic gen_file();
        int unsigned segs;
        int unsigned s;
        int unsigned k;
        int unsigned n;
        logic [31:0] mk;
        segs = $urandom_range(1, 3);
        for (s = 0; s < segs; s++) begin
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++)
                push_byte(8'($urandom_range(0, 255)));
            mk = pick_marker();
            if ($urandom_range(0, 7) == 0)
                push_marker(mk, $urandom_range(1, 3));
            push_marker(mk, 4);
            n = $urandom_range(0, 2);
            for (k = 0; k < n; k++)
                push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            case ($urandom_range(0, 5))
                0:       push_marker(pick_marker(), 4);
                1:       push_marker(pick_marker(), $urandom_range(1, 3));
                default: ;
            endcase
            n = $urandom_range(0, 5);
            for (k = 0; k < n; k++)
                push_byte(pick_text_byte());
            if ($urandom_range(0, 3) == 0) begin
                push_byte(CH_SPACE);
                push_byte(CH_DOLLAR);
            end
            case ($urandom_range(0, 6))
                0:       push_byte(CH_NUL);
                1:       push_byte(CH_GT);
                2:       push_byte(CH_QUOTE);
                3:       push_byte(CH_BSL);
                4, 5:    push_byte(CH_LF);
                default: ;
            endcase
        end
        if ($urandom_range(0, 7) != 0)
            push_end();
    endtask

    task automatic gen_files(int unsigned count);
        int unsigned start;
        start = queued;
        while (queued - start < count)
            gen_file();
    endtask

    // sender holds off until every expected word is in, then lets the block settle
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pending.size() != 0 || in_if.valid || exp_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_first_only(logic v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        first_only_m = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'h00;
        in_if.is_end    = 1'b0;
        out_if.ready    = 1'b0;
        first_only_m    = 1'b0;
        matched_any     = 1'b0;
        queued          = 0;
        err_cnt         = 0;
        cycle_cnt       = 0;
        src_gap         = 0;
        snk_gap         = 0;
        calm            = 1'b0;
        clear_file_state();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_first_only(1'b0);

        // tab skip, repeated marker, 0xFF text, NUL terminator
        push_marker(MARK_SCCS, 4);
        push_byte(CH_TAB);
        push_marker(MARK_SCCS, 4);
        push_byte(8'hFF);
        push_byte(CH_NUL);
        // failed repeated marker becomes text, trailing " $" dropped at newline
        push_marker(MARK_ID, 4);
        push_marker(MARK_ID, 2);
        push_byte(CH_LOWER_X);
        push_byte(CH_SPACE);
        push_byte(CH_DOLLAR);
        push_byte(CH_LF);
        // end of file while skipping: held "$" flushes as a string
        push_marker(MARK_SCCS, 4);
        push_byte(CH_DOLLAR);
        push_end();
        wait_drained();

        write_first_only(1'b1);
        gen_files(25);
        wait_drained();

        write_first_only(1'b0);
        gen_files(25);
        wait_drained();

        // last part: no idling on either side
        write_first_only(1'b1);
        calm = 1'b1;
        gen_files(20);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (err_cnt == 0 && exp_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
